@@ rtl/fta_pkg.sv @@
// Package for the single-precision truncating adder.
// Operand and sum payload structs and the shared shift-limit constant; no dependencies.
`default_nettype none
package fta_pkg;
    localparam logic [4:0] SHIFT_LIMIT = 5'd25;

    typedef struct packed {
        logic        a_sign;
        logic [7:0]  a_exp;
        logic [22:0] a_frac;
        logic        b_sign;
        logic [7:0]  b_exp;
        logic [22:0] b_frac;
    } operands_t;

    typedef struct packed {
        logic        sum_sign;
        logic [7:0]  sum_exp;
        logic [22:0] sum_frac;
        logic        range_flag;
    } sum_t;
endpackage
`default_nettype wire

@@ rtl/float32_truncating_adder.sv @@
// Top level of the single-precision truncating adder.
// Depends on fta_pkg for the payload structs.
//
//   channel | direction | payload    | handshake
//   in      | into      | operands_t | in_valid / in_stall
//   out     | out of    | sum_t      | out_valid / out_stall
//
// Operands are registered, then align, add and normalize run in one pass
// into the result register.
// One operand pair is taken every cycle while in_stall is low; the two stages advance together
// whenever the result register is empty or being drained.
// A stall on the output while a result is held freezes both stages and raises in_stall.
// Reset clears both valid bits; payload registers are not reset.
`default_nettype none
module float32_truncating_adder
    import fta_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire operands_t in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output sum_t           out_data
);
    operands_t op_reg;
    logic      op_valid_reg;
    sum_t      res_reg;
    logic      res_valid_reg;
    logic      advance;
    sum_t      res_next;

    assign advance   = !res_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            op_valid_reg  <= in_valid;
            res_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_reg  <= in_data;
            res_reg <= res_next;
        end
    end

    // Align, add, normalize
    logic        a_big;
    logic [7:0]  diff;
    logic [23:0] ma, mb, m_big, m_small, m_shift;
    logic [24:0] mag;
    logic [8:0]  e_big;
    logic [4:0]  lz;
    logic        found;
    logic [9:0]  e_norm;
    logic        sign;

    always_comb
    begin
        ma    = {1'b1, op_reg.a_frac};
        mb    = {1'b1, op_reg.b_frac};
        a_big = op_reg.a_exp > op_reg.b_exp;
        if (a_big)
        begin
            diff    = op_reg.a_exp - op_reg.b_exp;
            m_big   = ma;
            m_small = mb;
            e_big   = {1'b0, op_reg.a_exp};
        end
        else
        begin
            diff    = op_reg.b_exp - op_reg.a_exp;
            m_big   = mb;
            m_small = ma;
            e_big   = {1'b0, op_reg.b_exp};
        end
        m_shift = (diff >= {3'b0, SHIFT_LIMIT}) ? 24'd0 : (m_small >> diff[4:0]);

        // aligned mantissas back in a/b order for the sign decision
        if (op_reg.a_sign == op_reg.b_sign)
        begin
            mag  = {1'b0, m_big} + {1'b0, m_shift};
            sign = op_reg.a_sign;
        end
        else if (a_big ? (m_big > m_shift) : (m_shift > m_big))
        begin
            mag  = a_big ? {1'b0, m_big - m_shift} : {1'b0, m_shift - m_big};
            sign = op_reg.a_sign;
        end
        else
        begin
            mag  = a_big ? {1'b0, m_shift - m_big} : {1'b0, m_big - m_shift};
            sign = op_reg.b_sign;
        end

        // leading-zero count over bits 23..0
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--)
        begin
            if (!found && mag[i])
            begin
                found = 1'b1;
                lz    = 5'(23 - i);
            end
        end

        res_next.range_flag = 1'b0;
        res_next.sum_sign   = sign;
        if (mag == 25'd0)
        begin
            res_next.sum_sign = 1'b0;
            res_next.sum_exp  = 8'd0;
            res_next.sum_frac = 23'd0;
        end
        else if (mag[24])
        begin
            e_norm = {1'b0, e_big} + 10'd1;
            if (e_norm > 10'd255)
            begin
                res_next.sum_exp    = 8'd255;
                res_next.sum_frac   = 23'd0;
                res_next.range_flag = 1'b1;
            end
            else
            begin
                res_next.sum_exp  = e_norm[7:0];
                res_next.sum_frac = mag[23:1];
            end
        end
        else
        begin
            if ({4'b0, lz} > e_big)
            begin
                res_next.sum_sign   = 1'b0;
                res_next.sum_exp    = 8'd0;
                res_next.sum_frac   = 23'd0;
                res_next.range_flag = 1'b1;
            end
            else
            begin
                res_next.sum_exp  = 8'(e_big - {4'b0, lz});
                res_next.sum_frac = 23'(mag[23:0] << lz);
            end
        end
        e_norm = {1'b0, e_big};
    end

    // Checks
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg && !in_stall |=> out_valid)
        else $error("registered operands lost");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.range_flag && out_data.sum_exp == 8'd0
        |-> !out_data.sum_sign && out_data.sum_frac == 23'd0)
        else $error("underflow result not zero");
endmodule
`default_nettype wire
